// ===== hdl/dbrd_pkg.sv =====
// ----------------------------------------------------------------------------
// dbrd_pkg
// Shared types, codes and divisor tables for the dual baud rate divider.
// ----------------------------------------------------------------------------
package dbrd_pkg;

   localparam int QUARTER_DIVIDE      = 4;
   localparam int QUARTER_COUNT_WIDTH = $clog2(QUARTER_DIVIDE);

   localparam int COUNT_WIDTH    = 13;
   localparam int SELECT_WIDTH   = 4;
   localparam int TABLE_WIDTH    = 2;
   localparam int VALUE_WIDTH    = 8;
   localparam int REQ_TYPE_WIDTH = 2;

   localparam int CSR_INDEX_WIDTH = 1;
   localparam int CSR_DATA_WIDTH  = TABLE_WIDTH;

   typedef enum logic [REQ_TYPE_WIDTH-1:0] {
      REQ_TICK     = 2'd0,
      REQ_WRITE_RX = 2'd1,
      REQ_WRITE_TX = 2'd2
   } req_code_type;

   typedef enum logic [TABLE_WIDTH-1:0] {
      TABLE_16X_5M0688 = 2'd0,
      TABLE_16X_4M9152 = 2'd1,
      TABLE_32X_5M0688 = 2'd2
   } table_code_type;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_RX_TABLE_SELECT = 1'd0,
      CSR_TX_TABLE_SELECT = 1'd1
   } csr_index_type;

   // Control for one divider channel.
   typedef struct packed {
      logic                    tick;
      logic                    load;
      logic [SELECT_WIDTH-1:0] load_select;
      logic [TABLE_WIDTH-1:0]  table_code;
   } chan_ctrl_type;

   typedef logic [COUNT_WIDTH-1:0] divisor_row_type [0:15];

   localparam divisor_row_type TABLE_A = '{
      13'd6336, 13'd4224, 13'd2880, 13'd2355, 13'd2112, 13'd1056, 13'd528, 13'd264,
      13'd176,  13'd158,  13'd132,  13'd88,   13'd66,   13'd44,   13'd33,  13'd16
   };
   localparam divisor_row_type TABLE_B = '{
      13'd6144, 13'd4096, 13'd2793, 13'd2284, 13'd2048, 13'd1024, 13'd512, 13'd256,
      13'd171,  13'd154,  13'd128,  13'd85,   13'd64,   13'd43,   13'd32,  13'd16
   };
   localparam divisor_row_type TABLE_C = '{
      13'd3168, 13'd2112, 13'd1440, 13'd1177, 13'd1056, 13'd792, 13'd528, 13'd264,
      13'd132,  13'd88,   13'd66,   13'd44,   13'd33,   13'd22,  13'd16,  13'd8
   };

   // Unused table code falls back to the first table.
   function automatic logic [COUNT_WIDTH-1:0] lookup_divisor(
      input logic [TABLE_WIDTH-1:0]  table_code,
      input logic [SELECT_WIDTH-1:0] sel
   );
      logic [COUNT_WIDTH-1:0] result;
      case (table_code)
         TABLE_16X_4M9152: result = TABLE_B[sel];
         TABLE_32X_5M0688: result = TABLE_C[sel];
         default:          result = TABLE_A[sel];
      endcase
      return result;
   endfunction

endpackage

// ===== hdl/dbrd_req_if.sv =====
// ----------------------------------------------------------------------------
// dbrd_req_if
// Request channel: tick and select-write items with valid/ready handshake.
// ----------------------------------------------------------------------------
interface dbrd_req_if;
   import dbrd_pkg::*;

   logic                      valid;
   logic                      ready;
   logic [REQ_TYPE_WIDTH-1:0] req_type;
   logic [VALUE_WIDTH-1:0]    select_value;

   modport source (output valid, req_type, select_value, input ready);
   modport sink   (input valid, req_type, select_value, output ready);
endinterface

// ===== hdl/dbrd_rsp_if.sv =====
// ----------------------------------------------------------------------------
// dbrd_rsp_if
// Result channel: the quarter, rx and tx clock pulse bits of one item, valid/ready handshake.
// ----------------------------------------------------------------------------
interface dbrd_rsp_if;
   logic valid;
   logic ready;
   logic quarter_clock_pulse;
   logic rx_clock_pulse;
   logic tx_clock_pulse;

   modport source (output valid, quarter_clock_pulse, rx_clock_pulse, tx_clock_pulse,
                   input ready);
   modport sink   (input valid, quarter_clock_pulse, rx_clock_pulse, tx_clock_pulse,
                   output ready);
endinterface

// ===== hdl/dbrd_channel.sv =====
// ----------------------------------------------------------------------------
// dbrd_channel
// One programmable divider: select register, tick counter and run flag.
// ----------------------------------------------------------------------------
module dbrd_channel (
   input  logic                   clock,
   input  logic                   reset,
   input  dbrd_pkg::chan_ctrl_type ctrl,
   output logic                   pulse
);
   import dbrd_pkg::*;

   logic [SELECT_WIDTH-1:0] select_ff, select_in;
   logic [COUNT_WIDTH-1:0]  count_ff, count_in;
   logic                    running_ff, running_in;
   logic [COUNT_WIDTH-1:0]  divisor;
   logic [COUNT_WIDTH:0]    count_next;

   // Divisor follows the current table register on every tick.
   assign divisor    = lookup_divisor(ctrl.table_code, select_ff);
   assign count_next = {1'b0, count_ff} + {{COUNT_WIDTH{1'b0}}, 1'b1};
   assign pulse      = ctrl.tick && running_ff && (count_next >= {1'b0, divisor});

   always_comb begin
      select_in  = select_ff;
      count_in   = count_ff;
      running_in = running_ff;
      if (ctrl.load) begin
         select_in  = ctrl.load_select;
         count_in   = '0;
         running_in = 1'b1;
      end else if (ctrl.tick && running_ff) begin
         if (pulse) begin
            count_in = '0;
         end else begin
            count_in = count_next[COUNT_WIDTH-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         select_ff  <= '0;
         count_ff   <= '0;
         running_ff <= 1'b0;
      end else begin
         select_ff  <= select_in;
         count_ff   <= count_in;
         running_ff <= running_in;
      end
   end

   a_load_restarts: assert property (@(posedge clock) disable iff (reset)
      ctrl.load |=> (count_ff == '0) && running_ff)
      else $error("channel did not restart on select write");

   a_silent_when_stopped: assert property (@(posedge clock) disable iff (reset)
      !running_ff |-> !pulse)
      else $error("stopped channel pulsed");

   a_pulse_clears: assert property (@(posedge clock) disable iff (reset)
      pulse |=> (count_ff == '0))
      else $error("counter not cleared after pulse");

endmodule

// ===== hdl/dual_baud_rate_divider.sv =====
// ----------------------------------------------------------------------------
// dual_baud_rate_divider
// One item is taken per clock and its result appears in the output register
// on the next cycle; the block keeps taking items while that result waits, as
// long as the output register is free or being drained in the same cycle. All
// work for an item is the counter increment and divisor table compare of each
// channel, done in one pass between the state registers and the result
// register. A select write restarts its channel; a channel never written
// stays silent; write items and the unused request code give an all-zero
// result. There is no clearing pass after reset.
// ----------------------------------------------------------------------------
module dual_baud_rate_divider (
   input  logic                                clock,
   input  logic                                reset,
   dbrd_req_if.sink                            req_channel,
   dbrd_rsp_if.source                          rsp_channel,
   input  logic                                csr_write_enable,
   input  logic [dbrd_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [dbrd_pkg::CSR_DATA_WIDTH-1:0]  csr_write_data
);
   import dbrd_pkg::*;

   logic [TABLE_WIDTH-1:0]         rx_table_ff, rx_table_in;
   logic [TABLE_WIDTH-1:0]         tx_table_ff, tx_table_in;
   logic [QUARTER_COUNT_WIDTH-1:0] quarter_count_ff, quarter_count_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic                           quarter_pulse_ff, quarter_pulse_in;
   logic                           rx_pulse_ff, rx_pulse_in;
   logic                           tx_pulse_ff, tx_pulse_in;

   logic                           accept;
   logic                           tick;
   logic                           write_rx;
   logic                           write_tx;
   logic [QUARTER_COUNT_WIDTH:0]   quarter_next;
   logic                           quarter_pulse;
   logic                           rx_pulse;
   logic                           tx_pulse;
   chan_ctrl_type                  rx_ctrl;
   chan_ctrl_type                  tx_ctrl;

   assign req_channel.ready = !rsp_valid_ff || rsp_channel.ready;
   assign accept            = req_channel.valid && req_channel.ready;

   always_comb begin
      tick     = 1'b0;
      write_rx = 1'b0;
      write_tx = 1'b0;
      unique case (req_code_type'(req_channel.req_type))
         REQ_TICK:     tick     = accept;
         REQ_WRITE_RX: write_rx = accept;
         REQ_WRITE_TX: write_tx = accept;
         default: ;
      endcase
   end

   always_comb begin
      rx_table_in = rx_table_ff;
      tx_table_in = tx_table_ff;
      if (csr_write_enable) begin
         unique case (csr_index_type'(csr_index))
            CSR_RX_TABLE_SELECT: rx_table_in = csr_write_data;
            CSR_TX_TABLE_SELECT: tx_table_in = csr_write_data;
            default: ;
         endcase
      end
   end

   // Free-running divide-by-quarter counter, advanced on ticks only.
   assign quarter_next  = {1'b0, quarter_count_ff} + {{QUARTER_COUNT_WIDTH{1'b0}}, 1'b1};
   assign quarter_pulse = tick &&
                          (quarter_next >= (QUARTER_COUNT_WIDTH+1)'(QUARTER_DIVIDE));

   always_comb begin
      quarter_count_in = quarter_count_ff;
      if (tick) begin
         if (quarter_pulse) begin
            quarter_count_in = '0;
         end else begin
            quarter_count_in = quarter_next[QUARTER_COUNT_WIDTH-1:0];
         end
      end
   end

   assign rx_ctrl = '{tick:        tick,
                      load:        write_rx,
                      load_select: req_channel.select_value[SELECT_WIDTH-1:0],
                      table_code:  rx_table_ff};
   assign tx_ctrl = '{tick:        tick,
                      load:        write_tx,
                      load_select: req_channel.select_value[SELECT_WIDTH-1:0],
                      table_code:  tx_table_ff};

   dbrd_channel u_rx_channel (
      .clock (clock),
      .reset (reset),
      .ctrl  (rx_ctrl),
      .pulse (rx_pulse)
   );

   dbrd_channel u_tx_channel (
      .clock (clock),
      .reset (reset),
      .ctrl  (tx_ctrl),
      .pulse (tx_pulse)
   );

   // Result register: load on every input transfer, hold while stalled.
   always_comb begin
      rsp_valid_in     = rsp_valid_ff && !rsp_channel.ready;
      quarter_pulse_in = quarter_pulse_ff;
      rx_pulse_in      = rx_pulse_ff;
      tx_pulse_in      = tx_pulse_ff;
      if (accept) begin
         rsp_valid_in     = 1'b1;
         quarter_pulse_in = quarter_pulse;
         rx_pulse_in      = rx_pulse;
         tx_pulse_in      = tx_pulse;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rx_table_ff      <= '0;
         tx_table_ff      <= '0;
         quarter_count_ff <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         rx_table_ff      <= rx_table_in;
         tx_table_ff      <= tx_table_in;
         quarter_count_ff <= quarter_count_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      quarter_pulse_ff <= quarter_pulse_in;
      rx_pulse_ff      <= rx_pulse_in;
      tx_pulse_ff      <= tx_pulse_in;
   end

   assign rsp_channel.valid               = rsp_valid_ff;
   assign rsp_channel.quarter_clock_pulse = quarter_pulse_ff;
   assign rsp_channel.rx_clock_pulse      = rx_pulse_ff;
   assign rsp_channel.tx_clock_pulse      = tx_pulse_ff;

   a_write_gives_zero: assert property (@(posedge clock) disable iff (reset)
      accept && !tick |=> rsp_valid_ff && !quarter_pulse_ff && !rx_pulse_ff && !tx_pulse_ff)
      else $error("non-tick item produced a pulse");

   a_quarter_in_range: assert property (@(posedge clock) disable iff (reset)
      quarter_count_ff < QUARTER_COUNT_WIDTH'(QUARTER_DIVIDE - 1) ||
      quarter_count_ff == QUARTER_COUNT_WIDTH'(QUARTER_DIVIDE - 1))
      else $error("quarter counter out of range");

   a_quarter_wrap: assert property (@(posedge clock) disable iff (reset)
      tick && quarter_count_ff == QUARTER_COUNT_WIDTH'(QUARTER_DIVIDE - 1)
      |=> quarter_pulse_ff && quarter_count_ff == '0)
      else $error("quarter output missed its pulse");

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Drives tick and select-write transfers into the dual baud rate divider and
// checks every result against an in-bench prediction of the three pulse
// outputs, with random gaps and stalls on both channels and table changes
// made between phases.
// ----------------------------------------------------------------------------
module tb;
   import dbrd_pkg::*;

   localparam int WATCHDOG_LIMIT = 1000;
   localparam int MAX_REPORTS    = 10;

   localparam logic [REQ_TYPE_WIDTH-1:0] REQ_UNUSED   = 2'd3;
   localparam logic [TABLE_WIDTH-1:0]    TABLE_UNUSED = 2'd3;

   localparam logic [0:15][COUNT_WIDTH-1:0] RATES_16X_5M0688 = {
      13'd6336, 13'd4224, 13'd2880, 13'd2355, 13'd2112, 13'd1056, 13'd528, 13'd264,
      13'd176,  13'd158,  13'd132,  13'd88,   13'd66,   13'd44,   13'd33,  13'd16
   };
   localparam logic [0:15][COUNT_WIDTH-1:0] RATES_16X_4M9152 = {
      13'd6144, 13'd4096, 13'd2793, 13'd2284, 13'd2048, 13'd1024, 13'd512, 13'd256,
      13'd171,  13'd154,  13'd128,  13'd85,   13'd64,   13'd43,   13'd32,  13'd16
   };
   localparam logic [0:15][COUNT_WIDTH-1:0] RATES_32X_5M0688 = {
      13'd3168, 13'd2112, 13'd1440, 13'd1177, 13'd1056, 13'd792, 13'd528, 13'd264,
      13'd132,  13'd88,   13'd66,   13'd44,   13'd33,   13'd22,  13'd16,  13'd8
   };

   typedef struct packed {
      logic quarter;
      logic rx;
      logic tx;
   } pulse_set_type;

   logic                       clock = 1'b0;
   logic                       reset;
   logic                       csr_write_enable;
   logic [CSR_INDEX_WIDTH-1:0] csr_index;
   logic [CSR_DATA_WIDTH-1:0]  csr_write_data;

   dbrd_req_if req_if ();
   dbrd_rsp_if rsp_if ();

   dual_baud_rate_divider u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_channel      (req_if),
      .rsp_channel      (rsp_if),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always #5 clock = ~clock;

   // Predicted divider state
   logic [TABLE_WIDTH-1:0]  rx_table_code, tx_table_code;
   int                      quarter_phase;
   logic [SELECT_WIDTH-1:0] rx_sel, tx_sel;
   logic [COUNT_WIDTH-1:0]  rx_ticks, tx_ticks;
   logic                    rx_live, tx_live;

   pulse_set_type expected_pulses [$];
   int            fail_count   = 0;
   int            report_count = 0;
   int            idle_cycles  = 0;
   bit            sender_gaps  = 1'b1;

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 85) return $urandom_range(1, 3);
      if (roll < 95) return $urandom_range(4, 8);
      return $urandom_range(15, 40);
   endfunction

   function automatic logic [COUNT_WIDTH-1:0] baud_divisor(
      input logic [TABLE_WIDTH-1:0]  code,
      input logic [SELECT_WIDTH-1:0] sel
   );
      case (code)
         TABLE_16X_4M9152: return RATES_16X_4M9152[sel];
         TABLE_32X_5M0688: return RATES_32X_5M0688[sel];
         default:          return RATES_16X_5M0688[sel];
      endcase
   endfunction

   // Returns {pulse, next count} for one channel on a tick.
   function automatic logic [COUNT_WIDTH:0] advance_divider(
      input logic                   live,
      input logic [COUNT_WIDTH-1:0] count,
      input logic [COUNT_WIDTH-1:0] divisor
   );
      logic [COUNT_WIDTH:0] next_count;
      if (!live) return {1'b0, count};
      next_count = {1'b0, count} + {{COUNT_WIDTH{1'b0}}, 1'b1};
      if (next_count >= {1'b0, divisor}) return {1'b1, {COUNT_WIDTH{1'b0}}};
      return {1'b0, next_count[COUNT_WIDTH-1:0]};
   endfunction

   function automatic void clear_divider_state();
      rx_table_code = '0;
      tx_table_code = '0;
      quarter_phase = 0;
      rx_sel        = '0;
      tx_sel        = '0;
      rx_ticks      = '0;
      tx_ticks      = '0;
      rx_live       = 1'b0;
      tx_live       = 1'b0;
   endfunction

   function automatic pulse_set_type next_pulses(
      input logic [REQ_TYPE_WIDTH-1:0] code,
      input logic [VALUE_WIDTH-1:0]    value
   );
      pulse_set_type        pulses;
      logic [COUNT_WIDTH:0] rx_next, tx_next;
      pulses = '0;
      case (code)
         REQ_TICK: begin
            if (quarter_phase == QUARTER_DIVIDE - 1) begin
               quarter_phase  = 0;
               pulses.quarter = 1'b1;
            end else begin
               quarter_phase++;
            end
            // look the divisor up every tick so a table change applies at once
            rx_next   = advance_divider(rx_live, rx_ticks, baud_divisor(rx_table_code, rx_sel));
            tx_next   = advance_divider(tx_live, tx_ticks, baud_divisor(tx_table_code, tx_sel));
            pulses.rx = rx_next[COUNT_WIDTH];
            pulses.tx = tx_next[COUNT_WIDTH];
            rx_ticks  = rx_next[COUNT_WIDTH-1:0];
            tx_ticks  = tx_next[COUNT_WIDTH-1:0];
         end
         REQ_WRITE_RX: begin
            rx_sel   = value[SELECT_WIDTH-1:0];
            rx_ticks = '0;
            rx_live  = 1'b1;
         end
         REQ_WRITE_TX: begin
            tx_sel   = value[SELECT_WIDTH-1:0];
            tx_ticks = '0;
            tx_live  = 1'b1;
         end
         default: ;
      endcase
      return pulses;
   endfunction

   always @(posedge clock) begin : result_monitor
      pulse_set_type got, want;
      if (reset) begin
         clear_divider_state();
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               CSR_RX_TABLE_SELECT: rx_table_code = csr_write_data;
               CSR_TX_TABLE_SELECT: tx_table_code = csr_write_data;
               default: ;
            endcase
         end
         if (req_if.valid && req_if.ready)
            expected_pulses.push_back(next_pulses(req_if.req_type, req_if.select_value));
         if (rsp_if.valid && rsp_if.ready) begin
            got = {rsp_if.quarter_clock_pulse, rsp_if.rx_clock_pulse, rsp_if.tx_clock_pulse};
            if (expected_pulses.size() == 0) begin
               fail_count++;
               if (report_count < MAX_REPORTS) begin
                  report_count++;
                  $display("%0t: unexpected result q=%b rx=%b tx=%b",
                           $realtime, got.quarter, got.rx, got.tx);
               end
            end else begin
               want = expected_pulses.pop_front();
               if (got.quarter !== want.quarter || got.rx !== want.rx || got.tx !== want.tx)
               begin
                  fail_count++;
                  if (report_count < MAX_REPORTS) begin
                     report_count++;
                     $display("%0t: mismatch expected q=%b rx=%b tx=%b, actual q=%b rx=%b tx=%b",
                              $realtime, want.quarter, want.rx, want.tx,
                              got.quarter, got.rx, got.tx);
                  end
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Result side: bursts of ready, mostly short stalls, now and then a long one
   initial begin : rsp_stall_driver
      int run_len, stall_len;
      forever begin
         run_len = ($urandom_range(0, 19) == 0) ? $urandom_range(50, 200)
                                                : $urandom_range(1, 8);
         rsp_if.ready <= 1'b1;
         repeat (run_len) @(posedge clock);
         stall_len = pick_gap();
         if (stall_len > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (stall_len) @(posedge clock);
         end
      end
   end

   // Hold valid across back-to-back transfers; drop it only for a gap.
   task automatic send_req(
      input logic [REQ_TYPE_WIDTH-1:0] code,
      input logic [VALUE_WIDTH-1:0]    value
   );
      int gap;
      gap = sender_gaps ? pick_gap() : 0;
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid        <= 1'b1;
      req_if.req_type     <= code;
      req_if.select_value <= value;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
   endtask

   task automatic send_ticks(input int count);
      repeat (count) send_req(REQ_TICK, VALUE_WIDTH'($urandom_range(0, 255)));
   endtask

   // Drain all outstanding results before touching the tables.
   task automatic settle();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (expected_pulses.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic set_tables(
      input logic [TABLE_WIDTH-1:0] rx_code,
      input logic [TABLE_WIDTH-1:0] tx_code
   );
      csr_write_enable <= 1'b1;
      csr_index        <= CSR_RX_TABLE_SELECT;
      csr_write_data   <= rx_code;
      @(posedge clock);
      csr_index        <= CSR_TX_TABLE_SELECT;
      csr_write_data   <= tx_code;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic test_power_up_silence();
      send_ticks(6);
      send_req(REQ_UNUSED, 8'hFF);
      send_ticks(3);
   endtask

   task automatic test_select_writes();
      send_req(REQ_WRITE_RX, 8'hFF);
      send_req(REQ_WRITE_TX, 8'h0E);
      send_ticks(18);
      send_req(REQ_UNUSED, 8'h0F);
      send_req(REQ_WRITE_RX, 8'h00);
      send_ticks(3);
      send_req(REQ_WRITE_TX, 8'hF0);
      send_ticks(2);
   endtask

   task automatic test_table_switch();
      settle();
      set_tables(TABLE_16X_5M0688, TABLE_32X_5M0688);
      send_req(REQ_WRITE_RX, 8'h0F);
      send_req(REQ_WRITE_TX, 8'hAF);
      send_ticks(12);
      settle();
      // rx count already past its new divisor; tx falls back to the first table
      set_tables(TABLE_32X_5M0688, TABLE_UNUSED);
      send_ticks(20);
   endtask

   // Run both channels through a full period of a few hundred ticks.
   task automatic test_long_period();
      settle();
      set_tables(TABLE_16X_5M0688, TABLE_16X_4M9152);
      sender_gaps = 1'b0;
      send_req(REQ_WRITE_RX, 8'h37);
      send_req(REQ_WRITE_TX, 8'hC7);
      send_ticks(300);
      sender_gaps = 1'b1;
   endtask

   task automatic test_random_traffic();
      int                           roll;
      logic [SELECT_WIDTH-1:0]      sel;
      logic [VALUE_WIDTH-1:0]       value;
      logic [TABLE_WIDTH-1:0]       rx_code, tx_code;
      for (int phase = 0; phase < 7; phase++) begin
         settle();
         case (phase)
            0: begin rx_code = TABLE_32X_5M0688; tx_code = TABLE_16X_5M0688; end
            1: begin rx_code = TABLE_16X_5M0688; tx_code = TABLE_32X_5M0688; end
            default: begin
               rx_code = TABLE_WIDTH'($urandom_range(0, 3));
               tx_code = TABLE_WIDTH'($urandom_range(0, 3));
            end
         endcase
         set_tables(rx_code, tx_code);
         sender_gaps = (phase % 3 != 2);
         for (int n = 0; n < 100; n++) begin
            // favor short divisors so pulses come often
            sel   = ($urandom_range(0, 9) == 0) ? SELECT_WIDTH'($urandom_range(0, 15))
                                                : SELECT_WIDTH'($urandom_range(8, 15));
            value = {4'($urandom_range(0, 15)), sel};
            roll  = (n < 2) ? 90 + 6 * n : $urandom_range(0, 99);
            if (roll < 84)      send_req(REQ_TICK, value);
            else if (roll < 92) send_req(REQ_WRITE_RX, value);
            else if (roll < 98) send_req(REQ_WRITE_TX, value);
            else                send_req(REQ_UNUSED, value);
         end
      end
      sender_gaps = 1'b1;
   endtask

   task automatic finish_run();
      settle();
      repeat (8) @(posedge clock);
      if (fail_count == 0 && expected_pulses.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   endtask

   initial begin
      reset               <= 1'b1;
      req_if.valid        <= 1'b0;
      req_if.req_type     <= REQ_TICK;
      req_if.select_value <= '0;
      csr_write_enable    <= 1'b0;
      csr_index           <= CSR_RX_TABLE_SELECT;
      csr_write_data      <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      test_power_up_silence();
      test_select_writes();
      test_table_switch();
      test_long_period();
      test_random_traffic();
      finish_run();
   end

endmodule
